// ===== hdl/bclc_pkg.sv =====
// ----------------------------------------------------------------------------
// bclc_pkg
// Shared constants, register indexes and control types for the blob centroid
// line-crossing counter.
// ----------------------------------------------------------------------------
package bclc_pkg;

	localparam int FRAME_WIDTH = 640;
	localparam int CROP_HEIGHT = 460;
	localparam int COUNT_WIDTH = 16;

	localparam int COL_W      = 10;
	localparam int ROW_W      = 9;
	localparam int AREA_W     = 19;             // pixel count of a whole frame
	localparam int SUM_W      = 28;             // coordinate sums of a whole frame
	localparam int WEIGHT_W   = AREA_W + 8;     // 255 * pixel count
	localparam int MIN_AREA_W = 26;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 26;
	localparam int STEP_W     = $clog2(SUM_W);

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LINE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXIT_LINE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_COLUMN = 2'd3;

	localparam logic [MIN_AREA_W-1:0] MIN_AREA_RST     = MIN_AREA_W'(400);
	localparam logic [ROW_W-1:0]      ENTRY_LINE_RST   = ROW_W'(50);
	localparam logic [ROW_W-1:0]      EXIT_LINE_RST    = ROW_W'(430);
	localparam logic [COL_W-1:0]      SPLIT_COLUMN_RST = COL_W'(320);

	// Division select: bit 1 is the half, bit 0 picks row over column.
	localparam logic [1:0] DIV_LEFT_COL  = 2'd0;
	localparam logic [1:0] DIV_RIGHT_ROW = 2'd3;

	typedef struct packed {
		logic       acc_en;      // request accepted this cycle
		logic       div_load;
		logic       div_step;
		logic       div_store;
		logic [1:0] div_sel;
		logic       cross_en;
		logic       cross_half;
		logic       finish;      // load result, clear accumulators
	} bclc_cmd_t;

	typedef struct packed {
		logic out_pending;
	} bclc_sts_t;

endpackage

// ===== hdl/blob_centroid_line_crossing_counter.sv =====
// ----------------------------------------------------------------------------
// blob_centroid_line_crossing_counter
// Per-half blob centroids of a binary mask frame and a shared entry/exit
// line-crossing counter.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  pixel   | pixel_valid / pixel_stall  | mask_pixel, col, row, end_of_frame,
//          |                            | clear_counts
//  result  | result_valid / result_stall| entry_count, exit_count, left_x/y,
//          |                            | right_x/y, left_seen, right_seen
//  config  | cfg_we                     | cfg_index, cfg_data
//
// Pixels are taken one per cycle unless stalled. After the end-of-frame
// request the block stalls pixels for four centroid divisions of 28 quotient
// bits each on the one shared divider, two crossing tests and a result load.
// Ordinary pixels are still taken while a result waits to be taken; a new
// end-of-frame request waits until then. Reset loads the register defaults.
// ----------------------------------------------------------------------------
module blob_centroid_line_crossing_counter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bclc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bclc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  logic                                mask_pixel,
	input  logic [bclc_pkg::COL_W-1:0]          col,
	input  logic [bclc_pkg::ROW_W-1:0]          row,
	input  logic                                end_of_frame,
	input  logic                                clear_counts,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [bclc_pkg::COUNT_WIDTH-1:0]    entry_count,
	output logic [bclc_pkg::COUNT_WIDTH-1:0]    exit_count,
	output logic [bclc_pkg::COL_W-1:0]          left_x,
	output logic [bclc_pkg::ROW_W-1:0]          left_y,
	output logic [bclc_pkg::COL_W-1:0]          right_x,
	output logic [bclc_pkg::ROW_W-1:0]          right_y,
	output logic                                left_seen,
	output logic                                right_seen
);
	import bclc_pkg::*;

	bclc_cmd_t cmd;
	bclc_sts_t sts;

	bclc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.end_of_frame (end_of_frame),
		.pixel_stall  (pixel_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	bclc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mask_pixel   (mask_pixel),
		.col          (col),
		.row          (row),
		.clear_counts (clear_counts),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.entry_count  (entry_count),
		.exit_count   (exit_count),
		.left_x       (left_x),
		.left_y       (left_y),
		.right_x      (right_x),
		.right_y      (right_y),
		.left_seen    (left_seen),
		.right_seen   (right_seen)
	);

endmodule

// ===== hdl/bclc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bclc_ctrl
// Frame-end sequencer: four shared divisions, two crossing tests, result load.
// ----------------------------------------------------------------------------
module bclc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	input  logic                end_of_frame,
	output logic                pixel_stall,
	input  bclc_pkg::bclc_sts_t sts,
	output bclc_pkg::bclc_cmd_t cmd
);
	import bclc_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DLOAD  = 3'd1;
	localparam logic [2:0] ST_DSTEP  = 3'd2;
	localparam logic [2:0] ST_DSTORE = 3'd3;
	localparam logic [2:0] ST_CROSS0 = 3'd4;
	localparam logic [2:0] ST_CROSS1 = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0]        state_q;
	logic [1:0]        sel_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	// Stall while the sequencer is busy, and hold frame end back while the previous result has not been taken.
	assign pixel_stall = (state_q != ST_IDLE) | (sts.out_pending & end_of_frame);
	assign accept      = pixel_valid & ~pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= DIV_LEFT_COL;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && end_of_frame) begin
						state_q <= ST_DLOAD;
						sel_q   <= DIV_LEFT_COL;
					end
				end
				ST_DLOAD: begin
					state_q <= ST_DSTEP;
					step_q  <= '0;
				end
				ST_DSTEP: begin
					if (step_q == STEP_W'(SUM_W - 1)) state_q <= ST_DSTORE;
					else step_q <= step_q + 1'b1;
				end
				ST_DSTORE: begin
					if (sel_q == DIV_RIGHT_ROW) begin
						state_q <= ST_CROSS0;
					end else begin
						sel_q   <= sel_q + 1'b1;
						state_q <= ST_DLOAD;
					end
				end
				ST_CROSS0: state_q <= ST_CROSS1;
				ST_CROSS1: state_q <= ST_FINISH;
				ST_FINISH: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.acc_en     = accept;
		cmd.div_sel    = sel_q;
		cmd.div_load   = (state_q == ST_DLOAD);
		cmd.div_step   = (state_q == ST_DSTEP);
		cmd.div_store  = (state_q == ST_DSTORE);
		cmd.cross_en   = (state_q == ST_CROSS0) | (state_q == ST_CROSS1);
		cmd.cross_half = (state_q == ST_CROSS1);
		cmd.finish     = (state_q == ST_FINISH);
	end

endmodule

// ===== hdl/bclc_dp.sv =====
// ----------------------------------------------------------------------------
// bclc_dp
// Accumulators, shared restoring divider, positions, crossing logic, counters
// and the result register.
// ----------------------------------------------------------------------------
module bclc_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bclc_pkg::bclc_cmd_t                  cmd,
	output bclc_pkg::bclc_sts_t                  sts,
	input  logic                                 cfg_we,
	input  logic [bclc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bclc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 mask_pixel,
	input  logic [bclc_pkg::COL_W-1:0]           col,
	input  logic [bclc_pkg::ROW_W-1:0]           row,
	input  logic                                 clear_counts,
	input  logic                                 result_stall,
	output logic                                 result_valid,
	output logic [bclc_pkg::COUNT_WIDTH-1:0]     entry_count,
	output logic [bclc_pkg::COUNT_WIDTH-1:0]     exit_count,
	output logic [bclc_pkg::COL_W-1:0]           left_x,
	output logic [bclc_pkg::ROW_W-1:0]           left_y,
	output logic [bclc_pkg::COL_W-1:0]           right_x,
	output logic [bclc_pkg::ROW_W-1:0]           right_y,
	output logic                                 left_seen,
	output logic                                 right_seen
);
	import bclc_pkg::*;

	logic [MIN_AREA_W-1:0] min_area_q;
	logic [ROW_W-1:0]      entry_line_q;
	logic [ROW_W-1:0]      exit_line_q;
	logic [COL_W-1:0]      split_column_q;

	logic [AREA_W-1:0] area_q    [2];
	logic [SUM_W-1:0]  sum_col_q [2];
	logic [SUM_W-1:0]  sum_row_q [2];
	logic [COL_W-1:0]  last_col_q[2];
	logic [ROW_W-1:0]  last_row_q[2];
	logic [ROW_W-1:0]  prev_row_q[2];
	logic              seen_q    [2];
	logic              disarmed_q;
	logic [COUNT_WIDTH-1:0] entries_q;
	logic [COUNT_WIDTH-1:0] exits_q;

	logic [AREA_W-1:0] div_rem_q;
	logic [AREA_W-1:0] div_den_q;
	logic [SUM_W-1:0]  div_quo_q;
	logic [AREA_W:0]   div_shift;
	logic [AREA_W:0]   div_trial;
	logic              div_ge;

	logic              pix_in;
	logic              pix_half;
	logic              div_half;
	logic [WEIGHT_W-1:0] weight;
	logic              heavy;

	logic [ROW_W-1:0]  cy;
	logic [ROW_W-1:0]  cp;
	logic              c_seen;
	logic              c_entry;
	logic              c_exit;
	logic              c_dis1;
	logic              c_dis_next;

	logic              out_valid_q;

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_area_q     <= MIN_AREA_RST;
			entry_line_q   <= ENTRY_LINE_RST;
			exit_line_q    <= EXIT_LINE_RST;
			split_column_q <= SPLIT_COLUMN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_AREA:     min_area_q     <= cfg_data[MIN_AREA_W-1:0];
				CFG_ENTRY_LINE:   entry_line_q   <= cfg_data[ROW_W-1:0];
				CFG_EXIT_LINE:    exit_line_q    <= cfg_data[ROW_W-1:0];
				CFG_SPLIT_COLUMN: split_column_q <= cfg_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- moment accumulation ----
	assign pix_in   = mask_pixel & (col < COL_W'(FRAME_WIDTH)) & (row < ROW_W'(CROP_HEIGHT));
	assign pix_half = (col >= split_column_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < 2; h++) begin
				area_q[h]    <= '0;
				sum_col_q[h] <= '0;
				sum_row_q[h] <= '0;
			end
		end else if (cmd.finish) begin
			for (int h = 0; h < 2; h++) begin
				area_q[h]    <= '0;
				sum_col_q[h] <= '0;
				sum_row_q[h] <= '0;
			end
		end else if (cmd.acc_en && pix_in) begin
			area_q[pix_half]    <= area_q[pix_half] + 1'b1;
			sum_col_q[pix_half] <= sum_col_q[pix_half] + SUM_W'(col);
			sum_row_q[pix_half] <= sum_row_q[pix_half] + SUM_W'(row);
		end
	end

	// ---- shared divider, one quotient bit a cycle ----
	assign div_half  = cmd.div_sel[1];
	assign div_shift = {div_rem_q, div_quo_q[SUM_W-1]};
	assign div_ge    = (div_shift >= {1'b0, div_den_q});
	assign div_trial = div_shift - {1'b0, div_den_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			div_rem_q <= '0;
			div_den_q <= area_q[div_half];
			div_quo_q <= cmd.div_sel[0] ? sum_row_q[div_half] : sum_col_q[div_half];
		end else if (cmd.div_step) begin
			div_rem_q <= div_ge ? div_trial[AREA_W-1:0] : div_shift[AREA_W-1:0];
			div_quo_q <= {div_quo_q[SUM_W-2:0], div_ge};
		end
	end

	// weight = 255 * count
	assign weight = {area_q[div_half], 8'h00} - WEIGHT_W'(area_q[div_half]);
	assign heavy  = (weight > WEIGHT_W'(min_area_q));

	// ---- crossing test for one half ----
	assign cy      = last_row_q[cmd.cross_half];
	assign cp      = prev_row_q[cmd.cross_half];
	assign c_seen  = seen_q[cmd.cross_half];
	assign c_entry = (cp > cy) & (cy < entry_line_q) & ~disarmed_q;
	assign c_dis1  = disarmed_q | c_entry;
	assign c_exit  = (cp < cy) & (cy > exit_line_q) & ~c_dis1;
	assign c_dis_next = ((cy > entry_line_q) && (cy < exit_line_q)) ? 1'b0 : (c_dis1 | c_exit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < 2; h++) begin
				last_col_q[h] <= '0;
				last_row_q[h] <= '0;
				prev_row_q[h] <= '0;
				seen_q[h]     <= 1'b0;
			end
			disarmed_q <= 1'b0;
			entries_q  <= '0;
			exits_q    <= '0;
		end else begin
			if (cmd.div_store && heavy) begin
				if (cmd.div_sel[0]) begin
					last_row_q[div_half] <= div_quo_q[ROW_W-1:0];
					seen_q[div_half]     <= 1'b1;
				end else begin
					last_col_q[div_half] <= div_quo_q[COL_W-1:0];
				end
			end
			if (cmd.acc_en && clear_counts) begin
				entries_q <= '0;
				exits_q   <= '0;
			end else if (cmd.cross_en && c_seen) begin
				if (c_entry && (entries_q != '1)) entries_q <= entries_q + 1'b1;
				if (c_exit && (exits_q != '1)) exits_q <= exits_q + 1'b1;
			end
			if (cmd.cross_en && c_seen) begin
				disarmed_q                 <= c_dis_next;
				prev_row_q[cmd.cross_half] <= cy;
			end
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			entry_count <= entries_q;
			exit_count  <= exits_q;
			left_x      <= last_col_q[0];
			left_y      <= last_row_q[0];
			right_x     <= last_col_q[1];
			right_y     <= last_row_q[1];
			left_seen   <= seen_q[0];
			right_seen  <= seen_q[1];
		end
	end

	assign result_valid    = out_valid_q;
	assign sts.out_pending = out_valid_q;

endmodule

// ===== test/bclc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bclc_checker
// Watches the pixel, result and register ports of the blob centroid
// line-crossing counter, keeps its own copy of the per-half accumulators,
// positions and crossing counters, and compares every result taken with the
// oldest predicted frame tally.
// ----------------------------------------------------------------------------
module bclc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bclc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bclc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                pixel_valid,
	input  logic                                pixel_stall,
	input  logic                                mask_pixel,
	input  logic [bclc_pkg::COL_W-1:0]          col,
	input  logic [bclc_pkg::ROW_W-1:0]          row,
	input  logic                                end_of_frame,
	input  logic                                clear_counts,
	input  logic                                result_valid,
	input  logic                                result_stall,
	input  logic [bclc_pkg::COUNT_WIDTH-1:0]    entry_count,
	input  logic [bclc_pkg::COUNT_WIDTH-1:0]    exit_count,
	input  logic [bclc_pkg::COL_W-1:0]          left_x,
	input  logic [bclc_pkg::ROW_W-1:0]          left_y,
	input  logic [bclc_pkg::COL_W-1:0]          right_x,
	input  logic [bclc_pkg::ROW_W-1:0]          right_y,
	input  logic                                left_seen,
	input  logic                                right_seen,
	output int                                  fail_count,
	output int                                  pending_frames
);
	import bclc_pkg::*;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] entries;
		logic [COUNT_WIDTH-1:0] exits;
		logic [COL_W-1:0]       lx;
		logic [ROW_W-1:0]       ly;
		logic [COL_W-1:0]       rx;
		logic [ROW_W-1:0]       ry;
		logic                   ls;
		logic                   rs;
	} tally_t;

	tally_t expected_tallies[$];

	bit [MIN_AREA_W-1:0]  min_weight;
	bit [ROW_W-1:0]       entry_row;
	bit [ROW_W-1:0]       exit_row;
	bit [COL_W-1:0]       split_col;

	bit [AREA_W-1:0]      area_acc[2];
	bit [SUM_W-1:0]       col_acc[2];
	bit [SUM_W-1:0]       row_acc[2];
	bit [COL_W-1:0]       blob_x[2];
	bit [ROW_W-1:0]       blob_y[2];
	bit [ROW_W-1:0]       prior_y[2];
	bit                   found[2];
	bit                   disarmed;
	bit [COUNT_WIDTH-1:0] n_entries;
	bit [COUNT_WIDTH-1:0] n_exits;
	int                   mismatches;

	function automatic bit [COUNT_WIDTH-1:0] sat_inc(input bit [COUNT_WIDTH-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
	endtask

	// New position for one half when its weight beats the minimum; clear sums.
	task automatic settle_position(input int h);
		bit [WEIGHT_W-1:0] weight;
		weight = WEIGHT_W'(area_acc[h]) * WEIGHT_W'(255);
		if (weight > WEIGHT_W'(min_weight)) begin
			blob_x[h] = COL_W'(col_acc[h] / SUM_W'(area_acc[h]));
			blob_y[h] = ROW_W'(row_acc[h] / SUM_W'(area_acc[h]));
			found[h]  = 1'b1;
		end
		area_acc[h] = '0;
		col_acc[h]  = '0;
		row_acc[h]  = '0;
	endtask

	task automatic test_crossing(input int h);
		bit [ROW_W-1:0] y;
		bit [ROW_W-1:0] p;
		if (found[h]) begin
			y = blob_y[h];
			p = prior_y[h];
			if (p > y && y < entry_row && !disarmed) begin
				n_entries = sat_inc(n_entries);
				disarmed  = 1'b1;
			end
			if (p < y && y > exit_row && !disarmed) begin
				n_exits  = sat_inc(n_exits);
				disarmed = 1'b1;
			end
			// re-arm between the lines
			if (y > entry_row && y < exit_row)
				disarmed = 1'b0;
			prior_y[h] = y;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		tally_t want;
		tally_t t;
		int     h;
		if (!arst_n) begin
			min_weight = MIN_AREA_RST;
			entry_row  = ENTRY_LINE_RST;
			exit_row   = EXIT_LINE_RST;
			split_col  = SPLIT_COLUMN_RST;
			for (int i = 0; i < 2; i++) begin
				area_acc[i] = '0;
				col_acc[i]  = '0;
				row_acc[i]  = '0;
				blob_x[i]   = '0;
				blob_y[i]   = '0;
				prior_y[i]  = '0;
				found[i]    = 1'b0;
			end
			disarmed  = 1'b0;
			n_entries = '0;
			n_exits   = '0;
			expected_tallies.delete();
			mismatches = 0;
			fail_count     <= 0;
			pending_frames <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_AREA:     min_weight = cfg_data[MIN_AREA_W-1:0];
					CFG_ENTRY_LINE:   entry_row  = cfg_data[ROW_W-1:0];
					CFG_EXIT_LINE:    exit_row   = cfg_data[ROW_W-1:0];
					CFG_SPLIT_COLUMN: split_col  = cfg_data[COL_W-1:0];
					default: ;
				endcase
			end

			if (result_valid && !result_stall) begin
				if (expected_tallies.size() == 0) begin
					report("result with no frame end pending", 1, 0);
				end else begin
					want = expected_tallies.pop_front();
					if (entry_count !== want.entries) report("entry_count", entry_count, want.entries);
					if (exit_count !== want.exits)    report("exit_count", exit_count, want.exits);
					if (left_x !== want.lx)           report("left_x", left_x, want.lx);
					if (left_y !== want.ly)           report("left_y", left_y, want.ly);
					if (right_x !== want.rx)          report("right_x", right_x, want.rx);
					if (right_y !== want.ry)          report("right_y", right_y, want.ry);
					if (left_seen !== want.ls)        report("left_seen", left_seen, want.ls);
					if (right_seen !== want.rs)       report("right_seen", right_seen, want.rs);
				end
			end

			if (pixel_valid && !pixel_stall) begin
				// drop object pixels outside the frame
				if (mask_pixel && col < FRAME_WIDTH && row < CROP_HEIGHT) begin
					h = (col < split_col) ? 0 : 1;
					area_acc[h] = area_acc[h] + 1'b1;
					col_acc[h]  = col_acc[h] + SUM_W'(col);
					row_acc[h]  = row_acc[h] + SUM_W'(row);
				end
				if (clear_counts) begin
					n_entries = '0;
					n_exits   = '0;
				end
				if (end_of_frame) begin
					settle_position(0);
					settle_position(1);
					test_crossing(0);
					test_crossing(1);
					t.entries = n_entries;
					t.exits   = n_exits;
					t.lx      = blob_x[0];
					t.ly      = blob_y[0];
					t.rx      = blob_x[1];
					t.ry      = blob_y[1];
					t.ls      = found[0];
					t.rs      = found[1];
					expected_tallies.push_back(t);
				end
			end

			fail_count     <= mismatches;
			pending_frames <= expected_tallies.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel frames and register settings into the blob centroid
// line-crossing counter with random gaps and result stalls; a checker beside
// the block predicts and compares every frame result.
// ----------------------------------------------------------------------------
module testbench;
	import bclc_pkg::*;

	localparam int SETTLE_CYCLES = 140;    // frame-end processing plus margin
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 800;
	localparam int PHASES        = 8;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   pixel_valid;
	logic                   pixel_stall;
	logic                   mask_pixel;
	logic [COL_W-1:0]       col;
	logic [ROW_W-1:0]       row;
	logic                   end_of_frame;
	logic                   clear_counts;
	logic                   result_valid;
	logic                   result_stall;
	logic [COUNT_WIDTH-1:0] entry_count;
	logic [COUNT_WIDTH-1:0] exit_count;
	logic [COL_W-1:0]       left_x;
	logic [ROW_W-1:0]       left_y;
	logic [COL_W-1:0]       right_x;
	logic [ROW_W-1:0]       right_y;
	logic                   left_seen;
	logic                   right_seen;

	int fail_count;
	int pending_frames;
	int idle_cycles;
	int sent_items;
	bit no_gaps;
	int cur_entry;
	int cur_exit;
	int cur_split;

	blob_centroid_line_crossing_counter uut (.*);

	bclc_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Result side: hold stall for a random count before each result.
	initial begin : result_sink
		int n;
		result_stall = 1'b1;
		forever begin
			n = no_gaps ? 0 : $urandom_range(0, 4);
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	task automatic send_pixel(input bit pix, input int c, input int r, input bit eof,
			input bit clr);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid  <= 1'b1;
		mask_pixel   <= pix;
		col          <= COL_W'(c);
		row          <= ROW_W'(r);
		end_of_frame <= eof;
		clear_counts <= clr;
		do @(posedge clk); while (pixel_stall);
		sent_items++;
	endtask

	// Stop requests, wait for every pending result, then let the block go idle.
	task automatic drain_and_settle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending_frames != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input int ma, input int en, input int ex, input int sp);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIN_AREA;
		cfg_data  <= CFG_DATA_W'(ma);
		@(posedge clk);
		cfg_index <= CFG_ENTRY_LINE;
		cfg_data  <= CFG_DATA_W'(en);
		@(posedge clk);
		cfg_index <= CFG_EXIT_LINE;
		cfg_data  <= CFG_DATA_W'(ex);
		@(posedge clk);
		cfg_index <= CFG_SPLIT_COLUMN;
		cfg_data  <= CFG_DATA_W'(sp);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_entry = en % 512;
		cur_exit  = ex % 512;
		cur_split = sp % 1024;
	endtask

	initial begin : stimulus
		int phase;
		int target;
		int h;
		int n_obj;
		int tx;
		int ty;
		int c;
		int r;
		int left_hi;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_MIN_AREA;
		cfg_data     = '0;
		pixel_valid  = 1'b0;
		mask_pixel   = 1'b0;
		col          = '0;
		row          = '0;
		end_of_frame = 1'b0;
		clear_counts = 1'b0;
		no_gaps      = 1'b0;
		sent_items   = 0;
		cur_entry    = ENTRY_LINE_RST;
		cur_exit     = EXIT_LINE_RST;
		cur_split    = SPLIT_COLUMN_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone pixels stay under the minimum weight; out-of-frame requests drop
		send_pixel(1, 0, 0, 0, 0);
		send_pixel(1, 639, 459, 0, 0);
		send_pixel(1, 1023, 511, 0, 0);
		send_pixel(1, 640, 10, 0, 0);
		send_pixel(1, 10, 460, 0, 0);
		send_pixel(0, 5, 5, 1, 0);
		// first sighting: low right blob exits against a prior row of zero
		send_pixel(1, 100, 20, 0, 0);
		send_pixel(1, 101, 21, 0, 0);
		send_pixel(1, 320, 440, 0, 0);
		send_pixel(1, 321, 441, 1, 0);
		// left blob just left of the split moves to the middle, right half empty
		send_pixel(1, 319, 200, 0, 0);
		send_pixel(1, 318, 200, 1, 0);
		// left blob moves up above the entry line
		send_pixel(1, 50, 10, 0, 0);
		send_pixel(1, 50, 10, 1, 0);
		// clear outside a frame end, then an empty frame
		send_pixel(0, 0, 0, 0, 1);
		send_pixel(0, 0, 0, 1, 0);
		// clear on the frame-end request itself
		send_pixel(1, 600, 200, 0, 0);
		send_pixel(1, 601, 200, 0, 0);
		send_pixel(1, 602, 100, 1, 1);

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain_and_settle();
				case (phase)
					1: program_regs(0, 511, 0, 1023);
					2: program_regs(26'h3FFFFFF, 0, 511, 1);
					3: program_regs(254, 100, 300, 0);
					4: program_regs(255, 200, 260, $urandom_range(1, 639));
					default: program_regs($urandom_range(0, 1500), $urandom_range(0, 230),
							$urandom_range(230, 459), $urandom_range(1, 639));
				endcase
			end
			target = sent_items + RANDOM_ITEMS / PHASES;
			while (sent_items < target) begin
				no_gaps = ($urandom_range(0, 3) == 0);
				for (h = 0; h < 2; h++) begin
					left_hi = ((cur_split > FRAME_WIDTH) ? FRAME_WIDTH : cur_split) - 1;
					if (h == 0 && left_hi < 0)
						continue;
					if (h == 1 && cur_split >= FRAME_WIDTH)
						continue;
					tx = (h == 0) ? $urandom_range(0, left_hi) : $urandom_range(cur_split, 639);
					// aim near the lines so that crossings happen often
					case ($urandom_range(0, 3))
						0: ty = $urandom_range(0, cur_entry);
						1: ty = $urandom_range(cur_entry, cur_exit);
						2: ty = $urandom_range(cur_exit, 459);
						default: ty = $urandom_range(0, 459);
					endcase
					if (ty > 459)
						ty = 459;
					n_obj = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 40)
							: $urandom_range(0, 5);
					repeat (n_obj) begin
						if ($urandom_range(0, 3) == 0) begin
							case ($urandom_range(0, 2))
								0: send_pixel(0, $urandom_range(0, 1023), $urandom_range(0, 511),
										0, 0);
								1: send_pixel(1, $urandom_range(640, 1023), $urandom_range(0, 511),
										0, 0);
								default: send_pixel(1, $urandom_range(0, 639),
										$urandom_range(460, 511), 0, 0);
							endcase
						end
						c = tx + $urandom_range(0, 3);
						r = ty + $urandom_range(0, 3);
						if (c > 639)
							c = 639;
						if (r > 459)
							r = 459;
						send_pixel(1, c, r, 0, ($urandom_range(0, 31) == 0));
					end
				end
				send_pixel($urandom_range(0, 1), $urandom_range(0, 639), $urandom_range(0, 459),
						1, ($urandom_range(0, 15) == 0));
			end
		end

		no_gaps = 1'b0;
		drain_and_settle();
		if (fail_count == 0 && pending_frames == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
